// ----- hw/rtl/onb_pkg.sv -----
package onb_pkg;

    localparam int SQ_STEPS  = 15;
    localparam int PHI_STEPS = 14;
    localparam int MUL_STAGES = 4;
    localparam int QUO_STEPS = 48;

    localparam logic [15:0] COEF_A_RST = 16'd51413;
    localparam logic [15:0] COEF_B_RST = 16'd21685;
    localparam logic [15:0] FACTOR_MAX = 16'hFFFF;
    localparam logic [15:0] Q14_ONE    = 16'd16384;
    localparam logic [31:0] Q28_ONE    = 32'd268435456;

    typedef enum logic
    {
        REG_COEF_A = 1'b0,
        REG_COEF_B = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [28:0] rem;
        logic [29:0] root;
    } sq_t;

    typedef struct packed
    {
        logic [15:0] r;
        logic [13:0] q;
        logic        full;
        logic        neg;
    } lane_t;

    // Lanes: 0 is cos phi in, 1 is sin phi in, 2 is cos phi out, 3 is sin phi out.
    typedef struct packed
    {
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic signed [15:0] ix;
        logic signed [15:0] iy;
        logic signed [15:0] iz;
        logic [15:0]        cos_o;
        logic [15:0]        cos_i;
        sq_t                sq_o;
        sq_t                sq_i;
        logic               az;
        lane_t [3:0]        lane;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic [14:0]        sin_alpha;
        logic [14:0]        sin_num;
        logic [15:0]        divisor;
        logic [15:0]        maxcos;
        logic [29:0]        ss;
        logic [31:0]        bm;
        logic [59:0]        prod;
        logic               over;
        logic [15:0]        qr;
        logic [47:0]        qlo;
        logic [47:0]        quo;
        logic [15:0]        factor;
        logic               sat;
    } work_t;

    function automatic sq_t sqrt_step(input sq_t s, input logic [29:0] b);
        sq_t         r;
        logic [29:0] t;
        t = s.root + b;
        if ({1'b0, s.rem} >= t)
        begin
            r.rem  = 29'({1'b0, s.rem} - t);
            r.root = (s.root >> 1) + b;
        end
        else
        begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

    function automatic lane_t lane_setup(input logic signed [15:0] c, input logic [14:0] s);
        lane_t       l;
        logic [15:0] mag;
        mag    = c[15] ? 16'(-c) : 16'(c);
        l.full = mag >= {1'b0, s};
        l.r    = mag;
        l.q    = '0;
        l.neg  = c[15];
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t l, input logic [14:0] s);
        lane_t       n;
        logic [16:0] t;
        n = l;
        t = {l.r, 1'b0};
        if (t >= {2'b00, s})
        begin
            n.r = 16'(t - {2'b00, s});
            n.q = {l.q[12:0], 1'b1};
        end
        else
        begin
            n.r = t[15:0];
            n.q = {l.q[12:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic signed [15:0] lane_value(input lane_t l);
        logic signed [15:0] v;
        v = l.full ? $signed(Q14_ONE) : $signed({2'b00, l.q});
        return l.neg ? -v : v;
    endfunction

endpackage

// ----- hw/rtl/onb_ifs.sv -----
interface onb_dir_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_dir_x;
    logic signed [15:0] out_dir_y;
    logic signed [15:0] out_dir_z;
    logic signed [15:0] in_dir_x;
    logic signed [15:0] in_dir_y;
    logic signed [15:0] in_dir_z;

    modport source
    (
        output valid, out_dir_x, out_dir_y, out_dir_z, in_dir_x, in_dir_y, in_dir_z,
        input  ready
    );
    modport sink
    (
        input  valid, out_dir_x, out_dir_y, out_dir_z, in_dir_x, in_dir_y, in_dir_z,
        output ready
    );
endinterface

interface onb_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] brdf_factor;
    logic        saturated;

    modport source
    (
        output valid, brdf_factor, saturated,
        input  ready
    );
    modport sink
    (
        input  valid, brdf_factor, saturated,
        output ready
    );
endinterface

// ----- hw/rtl/onb_sqrt_pipe.sv -----
module onb_sqrt_pipe
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  onb_pkg::work_t in_data,
    output logic           out_valid,
    output onb_pkg::work_t out_data
);

    localparam int N = onb_pkg::SQ_STEPS + 1;

    onb_pkg::work_t st_reg  [N];
    onb_pkg::work_t st_next [N];
    logic [N-1:0]   vld_reg;

    always_comb
    begin
        logic [31:0] y2_o;
        logic [31:0] y2_i;
        y2_o = 32'(in_data.oy * in_data.oy);
        y2_i = 32'(in_data.iy * in_data.iy);
        st_next[0] = in_data;
        st_next[0].cos_o = in_data.oy[15] ? 16'(-in_data.oy) : 16'(in_data.oy);
        st_next[0].cos_i = in_data.iy[15] ? 16'(-in_data.iy) : 16'(in_data.iy);
        st_next[0].sq_o.rem  = (y2_o >= onb_pkg::Q28_ONE) ? '0 : 29'(onb_pkg::Q28_ONE - y2_o);
        st_next[0].sq_i.rem  = (y2_i >= onb_pkg::Q28_ONE) ? '0 : 29'(onb_pkg::Q28_ONE - y2_i);
        st_next[0].sq_o.root = '0;
        st_next[0].sq_i.root = '0;
        for (int k = 1; k < N; k++)
        begin
            st_next[k]      = st_reg[k-1];
            st_next[k].sq_o = onb_pkg::sqrt_step(st_reg[k-1].sq_o, 30'(1) << (28 - 2 * (k - 1)));
            st_next[k].sq_i = onb_pkg::sqrt_step(st_reg[k-1].sq_i, 30'(1) << (28 - 2 * (k - 1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data  = st_reg[N-1];

endmodule

// ----- hw/rtl/onb_phi_pipe.sv -----
module onb_phi_pipe
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  onb_pkg::work_t in_data,
    output logic           out_valid,
    output onb_pkg::work_t out_data
);

    localparam int N = onb_pkg::PHI_STEPS + 1;

    onb_pkg::work_t st_reg  [N];
    onb_pkg::work_t st_next [N];
    logic [N-1:0]   vld_reg;

    always_comb
    begin
        logic [14:0] sin_i;
        logic [14:0] sin_o;
        sin_i = in_data.sq_i.root[14:0];
        sin_o = in_data.sq_o.root[14:0];
        st_next[0]         = in_data;
        st_next[0].az      = (sin_i >= 15'd2) && (sin_o >= 15'd1);
        st_next[0].lane[0] = onb_pkg::lane_setup(in_data.ix, sin_i);
        st_next[0].lane[1] = onb_pkg::lane_setup(in_data.iz, sin_i);
        st_next[0].lane[2] = onb_pkg::lane_setup(in_data.ox, sin_o);
        st_next[0].lane[3] = onb_pkg::lane_setup(in_data.oz, sin_o);
        for (int k = 1; k < N; k++)
        begin
            st_next[k] = st_reg[k-1];
            for (int j = 0; j < 4; j++)
            begin
                st_next[k].lane[j] = onb_pkg::lane_step(st_reg[k-1].lane[j],
                    (j < 2) ? st_reg[k-1].sq_i.root[14:0] : st_reg[k-1].sq_o.root[14:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data  = st_reg[N-1];

endmodule

// ----- hw/rtl/onb_mul_pipe.sv -----
module onb_mul_pipe
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic [15:0]    coef_b,
    input  logic           in_valid,
    input  onb_pkg::work_t in_data,
    output logic           out_valid,
    output onb_pkg::work_t out_data
);

    localparam int N = onb_pkg::MUL_STAGES;

    onb_pkg::work_t st_reg  [N];
    onb_pkg::work_t st_next [N];
    logic [N-1:0]   vld_reg;

    always_comb
    begin
        logic signed [15:0] v0;
        logic signed [15:0] v1;
        logic signed [15:0] v2;
        logic signed [15:0] v3;
        logic signed [32:0] dcos;
        v0 = onb_pkg::lane_value(in_data.lane[0]);
        v1 = onb_pkg::lane_value(in_data.lane[1]);
        v2 = onb_pkg::lane_value(in_data.lane[2]);
        v3 = onb_pkg::lane_value(in_data.lane[3]);
        st_next[0]    = in_data;
        st_next[0].p1 = 32'(v0 * v2);
        st_next[0].p2 = 32'(v1 * v3);
        if (in_data.cos_i > in_data.cos_o)
        begin
            st_next[0].sin_alpha = in_data.sq_o.root[14:0];
            st_next[0].sin_num   = in_data.sq_i.root[14:0];
            st_next[0].divisor   = in_data.cos_i;
        end
        else
        begin
            st_next[0].sin_alpha = in_data.sq_i.root[14:0];
            st_next[0].sin_num   = in_data.sq_o.root[14:0];
            st_next[0].divisor   = in_data.cos_o;
        end

        dcos = 33'(st_reg[0].p1) + 33'(st_reg[0].p2);
        st_next[1]        = st_reg[0];
        st_next[1].maxcos = (st_reg[0].az && !dcos[32] && (dcos != '0)) ? dcos[29:14] : '0;
        st_next[1].ss     = 30'(st_reg[0].sin_alpha * st_reg[0].sin_num);

        st_next[2]    = st_reg[1];
        st_next[2].bm = 32'(coef_b * st_reg[1].maxcos);

        st_next[3]      = st_reg[2];
        st_next[3].prod = 60'(st_reg[2].bm * st_reg[2].ss);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data  = st_reg[N-1];

endmodule

// ----- hw/rtl/onb_quot_pipe.sv -----
module onb_quot_pipe
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic [15:0]    coef_a,
    input  logic           in_valid,
    input  onb_pkg::work_t in_data,
    output logic           out_valid,
    output onb_pkg::work_t out_data
);

    localparam int N = onb_pkg::QUO_STEPS + 2;

    onb_pkg::work_t st_reg  [N];
    onb_pkg::work_t st_next [N];
    logic [N-1:0]   vld_reg;

    always_comb
    begin
        logic [16:0] t;
        logic [48:0] total;
        st_next[0]      = in_data;
        st_next[0].over = {4'b0000, in_data.prod[59:48]} >= in_data.divisor;
        st_next[0].qr   = {4'b0000, in_data.prod[59:48]};
        st_next[0].qlo  = in_data.prod[47:0];
        st_next[0].quo  = '0;
        for (int k = 1; k < N - 1; k++)
        begin
            st_next[k] = st_reg[k-1];
            t = {st_reg[k-1].qr, st_reg[k-1].qlo[47]};
            if (t >= {1'b0, st_reg[k-1].divisor})
            begin
                st_next[k].qr  = 16'(t - {1'b0, st_reg[k-1].divisor});
                st_next[k].quo = {st_reg[k-1].quo[46:0], 1'b1};
            end
            else
            begin
                st_next[k].qr  = t[15:0];
                st_next[k].quo = {st_reg[k-1].quo[46:0], 1'b0};
            end
            st_next[k].qlo = {st_reg[k-1].qlo[46:0], 1'b0};
        end
        total = 49'({coef_a, 28'b0}) + 49'(st_reg[N-2].quo);
        st_next[N-1] = st_reg[N-2];
        if ((st_reg[N-2].divisor == '0) || st_reg[N-2].over || total[48])
        begin
            st_next[N-1].factor = onb_pkg::FACTOR_MAX;
            st_next[N-1].sat    = 1'b1;
        end
        else
        begin
            st_next[N-1].factor = total[47:32];
            st_next[N-1].sat    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_data  = st_reg[N-1];

endmodule

// ----- hw/rtl/oren_nayar_brdf_factor.sv -----
// An input transfer reaches its result through 16 square-root stages,
// 15 stages of the four azimuth dividers, 4 multiply stages and 50 quotient stages.
// Throughput is one direction pair per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits and loads the coefficients for roughness 0.5.
// Pipeline data registers are not reset.
module oren_nayar_brdf_factor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    onb_dir_if.sink     dirs,
    onb_res_if.source   result
);

    logic [15:0]    coef_a_reg;
    logic [15:0]    coef_b_reg;
    logic           adv;
    onb_pkg::work_t seed;
    logic           sq_valid;
    onb_pkg::work_t sq_data;
    logic           phi_valid;
    onb_pkg::work_t phi_data;
    logic           mul_valid;
    onb_pkg::work_t mul_data;
    logic           quo_valid;
    onb_pkg::work_t quo_data;
    onb_pkg::reg_idx_t reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = onb_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= onb_pkg::COEF_A_RST;
            coef_b_reg <= onb_pkg::COEF_B_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                onb_pkg::REG_COEF_A: coef_a_reg <= pwdata[15:0];
                onb_pkg::REG_COEF_B: coef_b_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            onb_pkg::REG_COEF_A: prdata = {16'b0, coef_a_reg};
            onb_pkg::REG_COEF_B: prdata = {16'b0, coef_b_reg};
            default:             prdata = '0;
        endcase
    end

    assign adv        = !quo_valid || result.ready;
    assign dirs.ready = adv;

    always_comb
    begin
        seed    = '0;
        seed.ox = dirs.out_dir_x;
        seed.oy = dirs.out_dir_y;
        seed.oz = dirs.out_dir_z;
        seed.ix = dirs.in_dir_x;
        seed.iy = dirs.in_dir_y;
        seed.iz = dirs.in_dir_z;
    end

    onb_sqrt_pipe u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dirs.valid),
        .in_data   (seed),
        .out_valid (sq_valid),
        .out_data  (sq_data)
    );

    onb_phi_pipe u_phi
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_data   (sq_data),
        .out_valid (phi_valid),
        .out_data  (phi_data)
    );

    onb_mul_pipe u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .coef_b    (coef_b_reg),
        .in_valid  (phi_valid),
        .in_data   (phi_data),
        .out_valid (mul_valid),
        .out_data  (mul_data)
    );

    onb_quot_pipe u_quot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .coef_a    (coef_a_reg),
        .in_valid  (mul_valid),
        .in_data   (mul_data),
        .out_valid (quo_valid),
        .out_data  (quo_data)
    );

    assign result.valid       = quo_valid;
    assign result.brdf_factor = quo_data.factor;
    assign result.saturated   = quo_data.sat;

endmodule

// ----- hw/rtl/onb_checker.sv -----
module onb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] factor,
    input logic        sat
);

    // A result that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(factor) && $stable(sat))
        else $error("stalled result changed");

    // A saturated result always carries the top code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sat |-> factor == 16'hFFFF)
        else $error("saturated result without top code");

    // The input side only waits while a result is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && !out_ready) |-> in_ready)
        else $error("input stalled without output stall");

    // A held result blocks new transfers on the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !(in_valid && in_ready))
        else $error("input transfer during output stall");

endmodule

bind oren_nayar_brdf_factor onb_checker u_onb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dirs.valid),
    .in_ready  (dirs.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .factor    (result.brdf_factor),
    .sat       (result.saturated)
);

// ----- tb/oren_nayar_brdf_factor_test.sv -----
module oren_nayar_brdf_factor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 85;
    localparam int N_RANDOM   = 1600;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed
    {
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic signed [15:0] ix;
        logic signed [15:0] iy;
        logic signed [15:0] iz;
    } dir_pair_t;

    typedef struct packed
    {
        logic [15:0] factor;
        logic        sat;
    } factor_t;

    typedef struct packed
    {
        dir_pair_t d;
        logic      known;
        factor_t   f;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    onb_dir_if dirs();
    onb_res_if result();

    oren_nayar_brdf_factor u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .dirs(dirs.sink),
        .result(result.source)
    );

    always #5 clk = ~clk;

    logic [15:0] coef_a_model = onb_pkg::COEF_A_RST;
    logic [15:0] coef_b_model = onb_pkg::COEF_B_RST;
    factor_t     pending_factors[$];
    int          errors = 0;
    int          idle_pct = 23;
    int          quiet_cycles = 0;

    function automatic longint polar_sine(input longint y);
        longint s2;
        longint r;
        s2 = 64'sd268435456 - y * y;
        if (s2 < 0)
            s2 = 0;
        r = 0;
        while ((r + 1) * (r + 1) <= s2)
            r = r + 1;
        return r;
    endfunction

    function automatic longint azimuth_ratio(input longint c, input longint s,
                                             input longint if_zero);
        longint q;
        if (s == 0)
            return if_zero;
        q = (c * 16384) / s;
        if (q > 16384)
            q = 16384;
        if (q < -16384)
            q = -16384;
        return q;
    endfunction

    function automatic factor_t predict_factor(input dir_pair_t d);
        factor_t f;
        longint sin_o, sin_i, cos_o, cos_i, max_cos, dcos;
        longint sin_alpha, sin_num, divisor;
        logic [63:0] prod, total, res;
        sin_o = polar_sine(d.oy);
        sin_i = polar_sine(d.iy);
        cos_o = d.oy < 0 ? -longint'(d.oy) : longint'(d.oy);
        cos_i = d.iy < 0 ? -longint'(d.iy) : longint'(d.iy);
        max_cos = 0;
        if (sin_i * 10000 > 16384 && sin_o * 100000 > 16384)
        begin
            dcos = azimuth_ratio(d.ix, sin_i, 16384) * azimuth_ratio(d.ox, sin_o, 16384)
                 + azimuth_ratio(d.iz, sin_i, 0) * azimuth_ratio(d.oz, sin_o, 0);
            if (dcos > 0)
                max_cos = dcos / 16384;
        end
        if (cos_i > cos_o)
        begin
            sin_alpha = sin_o;
            sin_num = sin_i;
            divisor = cos_i;
        end
        else
        begin
            sin_alpha = sin_i;
            sin_num = sin_o;
            divisor = cos_o;
        end
        f.sat = 1'b0;
        if (divisor == 0)
        begin
            f.factor = 16'hFFFF;
            f.sat = 1'b1;
        end
        else
        begin
            prod = 64'(coef_b_model) * 64'(max_cos) * 64'(sin_alpha) * 64'(sin_num);
            total = (64'(coef_a_model) << 28) + prod / 64'(divisor);
            res = total >> 32;
            if (res > 64'hFFFF)
            begin
                f.factor = 16'hFFFF;
                f.sat = 1'b1;
            end
            else
                f.factor = res[15:0];
        end
        return f;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic dir_pair_t rand_pair();
        dir_pair_t d;
        d.ox = rand_comp();
        d.oy = rand_comp();
        d.oz = rand_comp();
        d.ix = rand_comp();
        d.iy = rand_comp();
        d.iz = rand_comp();
        return d;
    endfunction

    task automatic write_coef(input onb_pkg::reg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == onb_pkg::REG_COEF_A)
            coef_a_model = value;
        else
            coef_b_model = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_pair(input dir_pair_t d, input logic known, input factor_t f);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            dirs.valid <= 1'b0;
            @(negedge clk);
        end
        dirs.valid <= 1'b1;
        dirs.out_dir_x <= d.ox;
        dirs.out_dir_y <= d.oy;
        dirs.out_dir_z <= d.oz;
        dirs.in_dir_x <= d.ix;
        dirs.in_dir_y <= d.iy;
        dirs.in_dir_z <= d.iz;
        pending_factors.push_back(known ? f : predict_factor(d));
        @(posedge clk);
        while (!dirs.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        dirs.valid <= 1'b0;
        while (pending_factors.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10)
            @(posedge clk);
    endtask

    initial
    begin
        dirs.valid = 1'b0;
        dirs.out_dir_x = '0;
        dirs.out_dir_y = '0;
        dirs.out_dir_z = '0;
        dirs.in_dir_x = '0;
        dirs.in_dir_y = '0;
        dirs.in_dir_z = '0;
        result.ready = 1'b0;
    end

    always @(negedge clk)
        result.ready <= ($urandom_range(0, 99) >= idle_pct);

    always @(posedge clk)
    begin
        factor_t want;
        if ((dirs.valid && dirs.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("oren_nayar_brdf_factor: mismatch");
            $finish;
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_factors.size() == 0)
            begin
                $display("%0t: unexpected transfer %h/%b", $time,
                         result.brdf_factor, result.saturated);
                errors++;
            end
            else
            begin
                want = pending_factors.pop_front();
                if (result.brdf_factor !== want.factor)
                begin
                    $display("%0t: brdf_factor expected %h actual %h", $time,
                             want.factor, result.brdf_factor);
                    errors++;
                end
                if (result.saturated !== want.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.sat, result.saturated);
                    errors++;
                end
            end
        end
    end

    row_t directed[] = '{
        '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b1,
          '{16'd3213, 1'b0}},
        '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b1,
          '{16'hFFFF, 1'b1}},
        '{'{16'sd0, -16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0}, 1'b1,
          '{16'd3213, 1'b0}},
        '{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd11585, 16'sd11585, 16'sd0}, 1'b0,
          '{16'd0, 1'b0}},
        '{'{-16'sd11585, 16'sd11585, 16'sd0, 16'sd11585, 16'sd11585, 16'sd0}, 1'b0,
          '{16'd0, 1'b0}},
        '{'{16'sd0, 16'sd11585, 16'sd11585, 16'sd0, 16'sd11585, 16'sd11585}, 1'b0,
          '{16'd0, 1'b0}},
        '{'{16'sd16384, 16'sd1, 16'sd0, 16'sd16384, 16'sd1, 16'sd0}, 1'b0,
          '{16'd0, 1'b0}},
        '{'{16'sd16384, 16'sd1, 16'sd0, 16'sd16384, 16'sd16383, 16'sd0}, 1'b0,
          '{16'd0, 1'b0}},
        '{'{16'sd2, 16'sd16383, 16'sd0, 16'sd2, 16'sd16383, 16'sd0}, 1'b0,
          '{16'd0, 1'b0}},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0,
          '{16'd0, 1'b0}},
        '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0,
          '{16'd0, 1'b0}},
        '{'{16'sh7FFF, 16'sd100, -16'sd3000, 16'sh8000, -16'sd200, 16'sd4000}, 1'b0,
          '{16'd0, 1'b0}},
        '{'{16'sd9000, 16'sd8000, 16'sd9000, 16'sd9000, 16'sd0, 16'sd9000}, 1'b0,
          '{16'd0, 1'b0}}
    };

    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (directed[k])
            send_pair(directed[k].d, directed[k].known, directed[k].f);
        drain();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_coef(onb_pkg::REG_COEF_A, 16'hFFFF);
                    write_coef(onb_pkg::REG_COEF_B, 16'hFFFF);
                end
                1:
                begin
                    write_coef(onb_pkg::REG_COEF_A, 16'h0000);
                    write_coef(onb_pkg::REG_COEF_B, 16'h0000);
                end
                2:
                begin
                    write_coef(onb_pkg::REG_COEF_A, 16'h0000);
                    write_coef(onb_pkg::REG_COEF_B, 16'hFFFF);
                end
                3:
                begin
                    write_coef(onb_pkg::REG_COEF_A, onb_pkg::COEF_A_RST);
                    write_coef(onb_pkg::REG_COEF_B, onb_pkg::COEF_B_RST);
                end
                default:
                begin
                    write_coef(onb_pkg::REG_COEF_A, 16'($urandom));
                    write_coef(onb_pkg::REG_COEF_B, 16'($urandom));
                end
            endcase
            idle_pct = (phase == 3) ? 0 : 23;
            for (int n = 0; n < N_RANDOM / 6; n++)
                send_pair(rand_pair(), 1'b0, '0);
            drain();
        end
        if (errors == 0)
            $display("oren_nayar_brdf_factor: match");
        else
            $display("oren_nayar_brdf_factor: mismatch");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/onb_pkg.sv
hw/rtl/onb_ifs.sv
hw/rtl/onb_sqrt_pipe.sv
hw/rtl/onb_phi_pipe.sv
hw/rtl/onb_mul_pipe.sv
hw/rtl/onb_quot_pipe.sv
hw/rtl/oren_nayar_brdf_factor.sv
hw/rtl/onb_checker.sv
tb/oren_nayar_brdf_factor_test.sv
